### rtl/core/jetcm_pkg.sv
// Shared constants and types of the jet colormap block.
// No dependencies; used by jet_colormap_top.
package jetcm_pkg;

  localparam int FRAC_BITS = 16;
  localparam int DATA_W    = 32;
  localparam int EXT_W     = DATA_W + 1;
  localparam int QUO_W     = FRAC_BITS + 2;
  localparam int REM_W     = EXT_W + FRAC_BITS;
  localparam int CMP_W     = EXT_W + QUO_W;
  localparam int QS_W      = QUO_W + 1;
  localparam int NRM_W     = QS_W + 2;
  localparam int VAL_W     = NRM_W + 1;
  localparam int RAMP_W    = FRAC_BITS + 1;
  localparam int CH_W      = 8;
  localparam int CFG_IDX_W = 2;

  localparam int ONE  = 1 << FRAC_BITS;
  localparam int HALF = ONE / 2;
  localparam int Q1   = ONE / 4;
  localparam int Q3   = (3 * ONE) / 4;

  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_LOW  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_RANGE_HIGH = CFG_IDX_W'(1);

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             kill;
    logic [REM_W-1:0] rem;
    logic [QUO_W-1:0] quo;
  } div_stage_t;

  typedef struct packed {
    logic              full;
    logic [RAMP_W-1:0] ramp;
  } chan_t;

endpackage

### rtl/core/jet_colormap_top.sv
// Jet colormap: signed fixed-point sample to 8-bit red, green, blue.
// Depends on jetcm_pkg for widths, register codes and stage types.
//
// One sample is taken on every clock at which start is high; busy stays low,
// cfg_ready stays high. Each result appears on out_red/out_green/out_blue with
// out_valid high for one cycle, in order. The sample passes an offset stage and
// a magnitude stage, then a chain of FRAC_BITS+2 register stages for the
// normalizing division, one quotient bit each, then three stages for the
// normalized position, curve segment and scale by 255; this chain sets the
// latency, and the rate is one sample per clock. The result side never
// stalls, so nothing is held.
// Write range_low and range_high only while no sample is in flight.
module jet_colormap_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic signed [jetcm_pkg::DATA_W-1:0] in_sample_value,
  output logic                               out_valid,
  output logic [jetcm_pkg::CH_W-1:0]         out_red,
  output logic [jetcm_pkg::CH_W-1:0]         out_green,
  output logic [jetcm_pkg::CH_W-1:0]         out_blue,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [jetcm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [jetcm_pkg::DATA_W-1:0]       cfg_data
);

  localparam int EXT_W  = jetcm_pkg::EXT_W;
  localparam int QUO_W  = jetcm_pkg::QUO_W;
  localparam int REM_W  = jetcm_pkg::REM_W;
  localparam int CMP_W  = jetcm_pkg::CMP_W;
  localparam int QS_W   = jetcm_pkg::QS_W;
  localparam int NRM_W  = jetcm_pkg::NRM_W;
  localparam int VAL_W  = jetcm_pkg::VAL_W;
  localparam int RAMP_W = jetcm_pkg::RAMP_W;
  localparam int CH_W   = jetcm_pkg::CH_W;
  localparam int FB     = jetcm_pkg::FRAC_BITS;

  localparam logic signed [NRM_W-1:0] ONE_N  = NRM_W'(jetcm_pkg::ONE);
  localparam logic signed [VAL_W-1:0] HALF_V = VAL_W'(jetcm_pkg::HALF);
  localparam logic signed [VAL_W-1:0] Q1_V   = VAL_W'(jetcm_pkg::Q1);
  localparam logic signed [VAL_W-1:0] Q3_V   = VAL_W'(jetcm_pkg::Q3);

  function automatic jetcm_pkg::chan_t chan_seg(input logic signed [VAL_W-1:0] v);
    jetcm_pkg::chan_t         c;
    logic signed [VAL_W-1:0]  d;
    c = '0;
    d = '0;
    if (v <= -Q3_V) begin
      c = '0;
    end else if (v <= -Q1_V) begin
      d = v + Q3_V;
      c.ramp = {d[RAMP_W-2:0], 1'b0};
    end else if (v <= Q1_V) begin
      c.full = 1'b1;
    end else if (v <= Q3_V) begin
      d = Q3_V - v;
      c.ramp = {d[RAMP_W-2:0], 1'b0};
    end
    return c;
  endfunction

  function automatic logic [CH_W-1:0] chan_scale(input jetcm_pkg::chan_t c);
    logic [RAMP_W+CH_W-1:0] prod;
    prod = {c.ramp, {CH_W{1'b0}}} - {{CH_W{1'b0}}, c.ramp};
    return c.full ? {CH_W{1'b1}} : prod[FB+CH_W-1:FB];
  endfunction

  // configuration
  logic signed [jetcm_pkg::DATA_W-1:0] range_low_r;
  logic signed [jetcm_pkg::DATA_W-1:0] range_high_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= jetcm_pkg::DATA_W'(jetcm_pkg::ONE);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        jetcm_pkg::CFG_RANGE_LOW:  range_low_r  <= cfg_data;
        jetcm_pkg::CFG_RANGE_HIGH: range_high_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // divisor magnitude and sign
  logic signed [EXT_W-1:0] den_nxt;
  logic [EXT_W-1:0]        den_abs_r;
  logic                    den_neg_r;
  logic                    den_zero_r;

  assign den_nxt = EXT_W'(range_high_r) - EXT_W'(range_low_r);

  always_ff @(posedge clk) begin
    den_abs_r  <= den_nxt[EXT_W-1] ? EXT_W'(-den_nxt) : den_nxt;
    den_neg_r  <= den_nxt[EXT_W-1];
    den_zero_r <= (den_nxt == '0);
  end

  // stage 0: offset against range_low
  logic                    s0_vld_r;
  logic signed [EXT_W-1:0] s0_diff_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_vld_r <= 1'b0;
    end else begin
      s0_vld_r <= start && !busy;
    end
    s0_diff_r <= EXT_W'(in_sample_value) - EXT_W'(range_low_r);
  end

  // stage 1: magnitudes, range check
  logic [EXT_W-1:0]      num_abs;
  jetcm_pkg::div_stage_t div_nxt [QUO_W+1];
  jetcm_pkg::div_stage_t div_r   [QUO_W+1];

  assign num_abs = s0_diff_r[EXT_W-1] ? EXT_W'(-s0_diff_r) : s0_diff_r;

  always_comb begin
    div_nxt[0].vld  = s0_vld_r;
    div_nxt[0].neg  = s0_diff_r[EXT_W-1] ^ den_neg_r;
    div_nxt[0].kill = den_zero_r || ({2'b00, num_abs} >= {den_abs_r, 2'b00});
    div_nxt[0].rem  = {num_abs, {FB{1'b0}}};
    div_nxt[0].quo  = '0;
  end

  // one quotient bit per stage
  for (genvar k = 0; k < QUO_W; k++) begin : g_div
    localparam int BIT = QUO_W - 1 - k;
    logic [CMP_W-1:0] den_sh;
    logic [CMP_W-1:0] rem_ext;
    logic [CMP_W-1:0] rem_sub;

    assign den_sh  = CMP_W'(den_abs_r) << BIT;
    assign rem_ext = CMP_W'(div_r[k].rem);
    assign rem_sub = rem_ext - den_sh;

    always_comb begin
      div_nxt[k+1] = div_r[k];
      if (rem_ext >= den_sh) begin
        div_nxt[k+1].rem      = rem_sub[REM_W-1:0];
        div_nxt[k+1].quo[BIT] = 1'b1;
      end
    end
  end

  for (genvar k = 0; k <= QUO_W; k++) begin : g_div_reg
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        div_r[k].vld <= 1'b0;
      end else begin
        div_r[k].vld <= div_nxt[k].vld;
      end
      div_r[k].neg  <= div_nxt[k].neg;
      div_r[k].kill <= div_nxt[k].kill;
      div_r[k].rem  <= div_nxt[k].rem;
      div_r[k].quo  <= div_nxt[k].quo;
    end
  end

  // normalized position n = 2q - 1
  logic signed [QS_W-1:0]  q_mag;
  logic signed [QS_W-1:0]  q_sgn;
  logic signed [NRM_W-1:0] n_nxt;
  logic                    f1_vld_r;
  logic                    f1_kill_r;
  logic signed [NRM_W-1:0] f1_n_r;

  assign q_mag = $signed({1'b0, div_r[QUO_W].quo});
  assign q_sgn = div_r[QUO_W].neg ? -q_mag : q_mag;
  assign n_nxt = $signed({q_sgn[QS_W-1], q_sgn, 1'b0}) - ONE_N;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_vld_r <= 1'b0;
    end else begin
      f1_vld_r <= div_r[QUO_W].vld;
    end
    f1_kill_r <= div_r[QUO_W].kill;
    f1_n_r    <= n_nxt;
  end

  // curve segment per channel
  logic signed [VAL_W-1:0] n_ext;
  jetcm_pkg::chan_t        red_nxt;
  jetcm_pkg::chan_t        grn_nxt;
  jetcm_pkg::chan_t        blu_nxt;
  logic                    f2_vld_r;
  jetcm_pkg::chan_t        red_r;
  jetcm_pkg::chan_t        grn_r;
  jetcm_pkg::chan_t        blu_r;

  assign n_ext = VAL_W'(f1_n_r);

  always_comb begin
    red_nxt = chan_seg(n_ext - HALF_V);
    grn_nxt = chan_seg(n_ext);
    blu_nxt = chan_seg(n_ext + HALF_V);
    if (f1_kill_r) begin
      red_nxt = '0;
      grn_nxt = '0;
      blu_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_vld_r <= 1'b0;
    end else begin
      f2_vld_r <= f1_vld_r;
    end
    red_r <= red_nxt;
    grn_r <= grn_nxt;
    blu_r <= blu_nxt;
  end

  // scale by 255 and drive the result beat
  logic            out_valid_r;
  logic [CH_W-1:0] out_red_r;
  logic [CH_W-1:0] out_green_r;
  logic [CH_W-1:0] out_blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= f2_vld_r;
    end
    out_red_r   <= chan_scale(red_r);
    out_green_r <= chan_scale(grn_r);
    out_blue_r  <= chan_scale(blu_r);
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_red_r;
  assign out_green = out_green_r;
  assign out_blue  = out_blue_r;

endmodule

### tb/testbench.sv
// Self-checking testbench for jet_colormap_top: directed probes, then random beats.
// Depends on jetcm_pkg and jet_colormap_top; predicts each color beat in-house.
`timescale 1ns / 100ps

module testbench;
  import jetcm_pkg::*;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] sample;
    logic              known;
    rgb_t              rgb;
  } probe_t;

  localparam int NUM_PROBES = 24;
  localparam int NUM_PHASES = 12;
  localparam int PHASE_BEATS = 75;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [DATA_W-1:0] in_sample_value = '0;
  logic out_valid;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_RANGE_LOW;
  logic [DATA_W-1:0] cfg_data = '0;

  logic known_rgb = 1'b0;
  rgb_t typed_rgb = '0;

  logic signed [DATA_W-1:0] range_low_copy = 0;
  logic signed [DATA_W-1:0] range_high_copy = ONE;
  rgb_t pending_rgb [$];
  int mismatches = 0;

  probe_t probe_rows [0:NUM_PROBES-1];

  jet_colormap_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_sample_value (in_sample_value),
    .out_valid       (out_valid),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 255 * trapezoid(v), truncated; v carries FRAC_BITS fraction bits
  function automatic logic [CH_W-1:0] ramp_level(input longint v);
    longint one_l;
    longint q1_l;
    longint q3_l;
    longint t;
    one_l = longint'(1) << FRAC_BITS;
    q1_l = one_l / 4;
    q3_l = (3 * one_l) / 4;
    if (v <= -q3_l) begin
      ramp_level = '0;
    end else if (v <= -q1_l) begin
      t = 2 * (v + q3_l);
      ramp_level = CH_W'((t * 255) >>> FRAC_BITS);
    end else if (v <= q1_l) begin
      ramp_level = 8'd255;
    end else if (v <= q3_l) begin
      t = 2 * (q3_l - v);
      ramp_level = CH_W'((t * 255) >>> FRAC_BITS);
    end else begin
      ramp_level = '0;
    end
  endfunction

  function automatic rgb_t jet_rgb(input logic signed [DATA_W-1:0] sample,
                                   input logic signed [DATA_W-1:0] lo,
                                   input logic signed [DATA_W-1:0] hi);
    longint one_l;
    longint span;
    longint q;
    longint n;
    rgb_t c;
    one_l = longint'(1) << FRAC_BITS;
    span = longint'(hi) - longint'(lo);
    if (span == 0) begin
      c = '0;
    end else begin
      q = ((longint'(sample) - longint'(lo)) * one_l) / span;
      if (q < -one_l) q = -one_l;
      if (q > 2 * one_l) q = 2 * one_l;
      n = 2 * q - one_l;
      c.red = ramp_level(n - one_l / 2);
      c.green = ramp_level(n);
      c.blue = ramp_level(n + one_l / 2);
    end
    jet_rgb = c;
  endfunction

  always @(posedge clk) begin : result_check
    rgb_t want;
    rgb_t next_rgb;
    if (!rst_n) begin
      range_low_copy = 0;
      range_high_copy = ONE;
      pending_rgb.delete();
    end else begin
      if (out_valid === 1'b1) begin
        if (pending_rgb.size() == 0) begin
          mismatches++;
          if (mismatches < 50)
            $display("%0t: unexpected beat, expected none, got %0d/%0d/%0d",
                     $time, out_red, out_green, out_blue);
        end else begin
          want = pending_rgb.pop_front();
          if (out_red !== want.red) begin
            mismatches++;
            if (mismatches < 50)
              $display("%0t: red expected %0d, got %0d", $time, want.red, out_red);
          end
          if (out_green !== want.green) begin
            mismatches++;
            if (mismatches < 50)
              $display("%0t: green expected %0d, got %0d", $time, want.green, out_green);
          end
          if (out_blue !== want.blue) begin
            mismatches++;
            if (mismatches < 50)
              $display("%0t: blue expected %0d, got %0d", $time, want.blue, out_blue);
          end
        end
      end
      if (start === 1'b1 && busy === 1'b0) begin
        next_rgb = known_rgb ? typed_rgb :
                   jet_rgb(in_sample_value, range_low_copy, range_high_copy);
        pending_rgb = {pending_rgb, next_rgb};
      end
      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        if (cfg_index == CFG_RANGE_LOW)
          range_low_copy = cfg_data;
        else if (cfg_index == CFG_RANGE_HIGH)
          range_high_copy = cfg_data;
      end
    end
  end

  task automatic send_sample(input logic [DATA_W-1:0] v, input logic known,
                             input rgb_t rgb);
    start <= 1'b1;
    in_sample_value <= v;
    known_rgb <= known;
    typed_rgb <= rgb;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic drain_results;
    start <= 1'b0;
    @(posedge clk);
    while (pending_rgb.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DATA_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
  endtask

  task automatic set_range(input logic [DATA_W-1:0] lo, input logic [DATA_W-1:0] hi);
    drain_results();
    write_reg(CFG_RANGE_LOW, lo);
    write_reg(CFG_RANGE_HIGH, hi);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [DATA_W-1:0] cur_lo;
    logic [DATA_W-1:0] cur_hi;
    logic signed [DATA_W-1:0] lo;
    logic signed [DATA_W-1:0] hi;
    logic [DATA_W-1:0] s;
    longint f;
    bit idle_on;

    probe_rows = '{
      {32'h0000_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 8'd0,   8'd0,   8'd127},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_8000, 1'b1, 8'd127, 8'd255, 8'd127},
      {32'h0000_0000, 32'h0001_0000, 32'h0001_0000, 1'b1, 8'd127, 8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_2000, 1'b1, 8'd0,   8'd0,   8'd255},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_E000, 1'b1, 8'd255, 8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h7FFF_FFFF, 1'b1, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h8000_0000, 1'b1, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'hFFFF_FFFF, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_6000, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_A000, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0001_0000, 32'h0000_2001, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h0003_0000, 32'h0003_0000, 32'h0003_0000, 1'b1, 8'd0,   8'd0,   8'd0},
      {32'h0003_0000, 32'h0003_0000, 32'h7FFF_FFFF, 1'b1, 8'd0,   8'd0,   8'd0},
      {32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 8'd0,   8'd0,   8'd0},
      {32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1, 8'd0,   8'd0,   8'd127},
      {32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 8'd127, 8'd0,   8'd0},
      {32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 1'b1, 8'd127, 8'd0,   8'd0},
      {32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1, 8'd0,   8'd0,   8'd127},
      {32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'hFFFF_0000, 32'h0001_0000, 32'h0000_0000, 1'b1, 8'd127, 8'd255, 8'd127},
      {32'h0001_0000, 32'h0000_0000, 32'h0000_4000, 1'b0, 8'd0,   8'd0,   8'd0},
      {32'h0000_0000, 32'h0000_0001, 32'h0000_0001, 1'b1, 8'd127, 8'd0,   8'd0},
      {32'h0000_0000, 32'h0000_0001, 32'h0000_0005, 1'b1, 8'd0,   8'd0,   8'd0}
    };
    cur_lo = 0;
    cur_hi = ONE;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (probe_rows[i]) begin
      if (probe_rows[i].lo != cur_lo || probe_rows[i].hi != cur_hi) begin
        set_range(probe_rows[i].lo, probe_rows[i].hi);
        cur_lo = probe_rows[i].lo;
        cur_hi = probe_rows[i].hi;
      end
      send_sample(probe_rows[i].sample, probe_rows[i].known, probe_rows[i].rgb);
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      case (ph)
        0: begin
          lo = 32'h8000_0000;
          hi = 32'h7FFF_FFFF;
        end
        1: begin
          lo = 32'h7FFF_FFFF;
          hi = 32'h8000_0000;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: begin
              lo = $urandom;
              hi = $urandom;
            end
            1: begin
              lo = $urandom;
              hi = lo;
            end
            2: begin
              lo = $signed($urandom) >>> $urandom_range(4, 16);
              hi = lo + ($signed($urandom) >>> $urandom_range(8, 24));
            end
            default: begin
              lo = $signed($urandom) >>> $urandom_range(8, 16);
              hi = lo + $urandom_range(1, 64);
            end
          endcase
        end
      endcase
      set_range(lo, hi);
      idle_on = (ph < NUM_PHASES - 2) && ($urandom_range(0, 3) != 0);

      for (int i = 0; i < PHASE_BEATS; i++) begin
        // hold off until the pipe is empty
        if (ph == 4 && i == PHASE_BEATS / 2)
          drain_results();
        if (idle_on && $urandom_range(0, 5) == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        if ($urandom_range(0, 3) == 0) begin
          s = $urandom;
        end else begin
          f = longint'($urandom_range(0, 98304)) - 16384;
          s = DATA_W'(longint'(lo) + (((longint'(hi) - longint'(lo)) * f) >>> 16));
        end
        send_sample(s, 1'b0, '0);
      end
    end

    drain_results();
    repeat (30) @(posedge clk);
    if (mismatches == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
